>>> rtl/pn3_pkg.sv
`default_nettype none
package pn3_pkg;

  localparam int unsigned FRAC_BITS_DEF    = 12;
  localparam int unsigned LATTICE_BITS_DEF = 8;
  localparam int unsigned COORD_W          = 20;
  localparam int unsigned OUT_W            = 16;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -16'sh8000;

  typedef logic [7:0] byte_t;

  function automatic byte_t perm(input byte_t i);
    byte_t r;
    case (i)
      8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
      8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
      8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
      8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
      8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
      8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
      8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
      8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
      8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
      8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
      8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
      8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
      8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
      8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
      8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
      8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
      8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
      8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
      8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
      8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
      8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
      8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
      8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
      8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
      8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
      8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
      8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
      8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
      8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
      8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
      8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
      8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
      8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
      8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
      8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
      8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
      8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
      8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
      8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
      8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
      8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
      8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
      8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
      8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
      8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
      8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
      8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
      8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
      8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
      8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
      8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
      8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
      8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
      8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
      8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
      8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
      8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
      8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
      8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
      8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
      8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
      8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
      8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
      8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // gradient dot product on Q16 offsets (-65536..65535), result fits 19 bits
  function automatic logic signed [18:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic signed [18:0] u;
    logic signed [18:0] v;
    u = (h < 4'd8) ? 19'(x) : 19'(y);
    if (h < 4'd4) v = 19'(y);
    else if (h == 4'd12 || h == 4'd14) v = 19'(x);
    else v = 19'(z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage
`default_nettype wire

>>> rtl/perlin_noise_3d.sv
`default_nettype none
// Improved 3D gradient noise, one coordinate word in, one noise word out.
// s_axis: tdata packs coord_x, coord_y, coord_z (20 bits each, Q8.FRAC_BITS).
// m_axis: tdata holds noise_value, signed Q1.14, saturated.
// An item enters every cycle while s_axis_tready is high. The pipeline is
// a chain of registered stages: permutation lookups take three stages, the
// fade polynomial four multiply stages, then the seven blends run as three
// multiply levels, each with its own rounding stage. Every stage holds a
// valid bit; a full stage holds its word while the stage after it cannot
// move on (ready is driven from the output side), so no word is lost or
// repeated. An empty stage lets the pipe fill up while the receiver stalls.
// Reset clears the valid bits only; no table setup is needed after reset.
module perlin_noise_3d #(
  parameter int unsigned FRAC_BITS    = pn3_pkg::FRAC_BITS_DEF,
  parameter int unsigned LATTICE_BITS = pn3_pkg::LATTICE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // coord_x[19:0], coord_y[39:20], coord_z[59:40]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // noise_value[15:0]
);

  localparam int NS = 14;
  localparam int LB = LATTICE_BITS;

  logic [NS-1:0] vld;
  logic          adv;
  // stage k loads when it is empty or the stage after it moves on
  logic [NS-1:0] ld;

  always_comb begin
    ld[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int k = NS-2; k >= 0; k--) ld[k] = !vld[k] || ld[k+1];
  end
  assign adv = ld[0];
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) if (ld[k]) vld[k] <= vld[k-1];
    end
  end

  // ---- offsets and lattice indexes
  logic [pn3_pkg::COORD_W-1:0] cx, cy, cz;
  assign cx = s_axis_tdata[19:0];
  assign cy = s_axis_tdata[39:20];
  assign cz = s_axis_tdata[59:40];

  function automatic logic [16:0] frac16(input logic [pn3_pkg::COORD_W-1:0] c);
    logic [15:0] f;
    f = 16'(c[FRAC_BITS-1:0]) << (16 - FRAC_BITS);
    return {1'b0, f};
  endfunction

  // per-axis carried values; t is Q16 fraction
  typedef struct packed {
    logic [16:0] tx, ty, tz;
  } frac_t;

  frac_t  fr [NS];
  logic [LB-1:0] gx0, gy0, gz0, gy1, gz1, gz2;
  logic [7:0] pa, pb;             // stage 1 outputs
  logic [7:0] a_s, b_s;           // stage 2
  logic [7:0] aa, ab, ba, bb;     // stage 3
  logic [7:0] hsh [8];            // stage 4

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      fr[0].tx <= frac16(cx);
      fr[0].ty <= frac16(cy);
      fr[0].tz <= frac16(cz);
      gx0 <= LB'(cx >> FRAC_BITS);
      gy0 <= LB'(cy >> FRAC_BITS);
      gz0 <= LB'(cz >> FRAC_BITS);
    end
    for (int k = 1; k < NS; k++) if (ld[k]) fr[k] <= fr[k-1];
    if (ld[1]) begin
      pa  <= pn3_pkg::perm(gx0);
      pb  <= pn3_pkg::perm(gx0 + 8'd1);
      gy1 <= gy0;
      gz1 <= gz0;
    end
    if (ld[2]) begin
      a_s <= pa + gy1;
      b_s <= pb + gy1;
      gz2 <= gz1;
    end
    if (ld[3]) begin
      aa <= pn3_pkg::perm(a_s) + gz2;
      ab <= pn3_pkg::perm(a_s + 8'd1) + gz2;
      ba <= pn3_pkg::perm(b_s) + gz2;
      bb <= pn3_pkg::perm(b_s + 8'd1) + gz2;
    end
    if (ld[4]) begin
      hsh[0] <= pn3_pkg::perm(aa);
      hsh[1] <= pn3_pkg::perm(ba);
      hsh[2] <= pn3_pkg::perm(ab);
      hsh[3] <= pn3_pkg::perm(bb);
      hsh[4] <= pn3_pkg::perm(aa + 8'd1);
      hsh[5] <= pn3_pkg::perm(ba + 8'd1);
      hsh[6] <= pn3_pkg::perm(ab + 8'd1);
      hsh[7] <= pn3_pkg::perm(bb + 8'd1);
    end
  end

  // ---- fade: stages 1..4 (one multiply per stage and axis)
  // a = 6t - 15*2^16 (fits 21 signed bits); products stay under 38 bits
  function automatic logic signed [37:0] rnd16(input logic signed [37:0] p);
    return (p + 38'sd32768) >>> 16;
  endfunction

  logic signed [21:0] fb [3];   // after stage 1: b
  logic signed [21:0] fc [3];   // after stage 2: c
  logic signed [21:0] fd [3];   // after stage 3: d
  logic [16:0]        fw [3];   // after stage 4: clamped f

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [21:0] t, a, f;
      t = (i == 0) ? 22'(fr[0].tx) : (i == 1) ? 22'(fr[0].ty) : 22'(fr[0].tz);
      a = 22'sd6 * t - 22'sd983040;
      if (ld[1]) fb[i] <= 22'(rnd16(38'(t) * 38'(a))) + 22'sd655360;
      t = (i == 0) ? 22'(fr[1].tx) : (i == 1) ? 22'(fr[1].ty) : 22'(fr[1].tz);
      if (ld[2]) fc[i] <= 22'(rnd16(38'(t) * 38'(fb[i])));
      t = (i == 0) ? 22'(fr[2].tx) : (i == 1) ? 22'(fr[2].ty) : 22'(fr[2].tz);
      if (ld[3]) fd[i] <= 22'(rnd16(38'(t) * 38'(fc[i])));
      t = (i == 0) ? 22'(fr[3].tx) : (i == 1) ? 22'(fr[3].ty) : 22'(fr[3].tz);
      f = 22'(rnd16(38'(t) * 38'(fd[i])));
      if (ld[4]) begin
        if (f < 0) fw[i] <= '0;
        else if (f > 22'sd65536) fw[i] <= 17'd65536;
        else fw[i] <= 17'(f);
      end
    end
  end

  // ---- stage 5: gradient dots
  logic [16:0]        w5 [3];
  logic signed [18:0] nd [8];

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      for (int c = 0; c < 8; c++) begin
        logic signed [17:0] ox, oy, oz;
        ox = c[0] ? 18'(fr[4].tx) - 18'sd65536 : 18'(fr[4].tx);
        oy = c[1] ? 18'(fr[4].ty) - 18'sd65536 : 18'(fr[4].ty);
        oz = c[2] ? 18'(fr[4].tz) - 18'sd65536 : 18'(fr[4].tz);
        nd[c] <= pn3_pkg::grad(hsh[c][3:0], ox, oy, oz);
      end
      for (int i = 0; i < 3; i++) w5[i] <= fw[i];
    end
  end

  // ---- blends: each level is a multiply stage then a round-add stage
  // level 1 (stages 6,7): four x blends on u
  logic signed [37:0] p1 [4];
  logic signed [18:0] a1 [4];
  logic signed [19:0] l1 [4];
  logic [16:0]        w6 [2], w7 [2];
  always_ff @(posedge clk) begin
    if (ld[6]) begin
      for (int j = 0; j < 4; j++) begin
        p1[j] <= 38'(w5[0]) * 38'(20'(nd[2*j+1]) - 20'(nd[2*j]));
        a1[j] <= nd[2*j];
      end
      w6[0] <= w5[1];
      w6[1] <= w5[2];
    end
    if (ld[7]) begin
      for (int j = 0; j < 4; j++) l1[j] <= 20'(a1[j]) + 20'(rnd16(p1[j]));
      w7 <= w6;
    end
  end

  // level 2 (stages 8,9): two y blends on v
  logic signed [38:0] p2 [2];
  logic signed [19:0] a2 [2];
  logic signed [20:0] l2 [2];
  logic [16:0]        w8, w9;
  always_ff @(posedge clk) begin
    if (ld[8]) begin
      for (int j = 0; j < 2; j++) begin
        p2[j] <= 39'(w7[0]) * 39'(21'(l1[2*j+1]) - 21'(l1[2*j]));
        a2[j] <= l1[2*j];
      end
      w8 <= w7[1];
    end
    if (ld[9]) begin
      for (int j = 0; j < 2; j++)
        l2[j] <= 21'(a2[j]) + 21'((p2[j] + 39'sd32768) >>> 16);
      w9 <= w8;
    end
  end

  // level 3 (stages 10,11): z blend on w
  logic signed [39:0] p3;
  logic signed [20:0] a3;
  logic signed [21:0] n3;
  always_ff @(posedge clk) begin
    if (ld[10]) begin
      p3 <= 40'(w9) * 40'(22'(l2[1]) - 22'(l2[0]));
      a3 <= l2[0];
    end
    if (ld[11]) n3 <= 22'(a3) + 22'((p3 + 40'sd32768) >>> 16);
  end

  // stage 12: scale to Q1.14; stage 13: saturate to output register
  logic signed [21:0] q12;
  logic [15:0]        q13;
  always_ff @(posedge clk) begin
    if (ld[12]) q12 <= (n3 + 22'sd2) >>> 2;
    if (ld[13]) begin
      if (q12 > 22'(pn3_pkg::OUT_MAX)) q13 <= pn3_pkg::OUT_MAX;
      else if (q12 < 22'(pn3_pkg::OUT_MIN)) q13 <= pn3_pkg::OUT_MIN;
      else q13 <= 16'(q12);
    end
  end
  assign m_axis_tdata = q13;

  // ---- assertions
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[NS-1] |-> s_axis_tready)
    else $error("pipe blocked with empty output stage");
  a_fade: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (w5[0] <= 17'd65536 && w5[1] <= 17'd65536 && w5[2] <= 17'd65536))
    else $error("fade out of range");

endmodule
`default_nettype wire

>>> sim/pn3_checker.sv
`timescale 1ns / 100ps
module pn3_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  output int               err_count,
  output int               pending,
  output int               sat_hits
);

  logic signed [15:0] noise_q[$];

  function automatic longint shr_fl(input longint a, input int k);
    return a >>> k;
  endfunction

  function automatic longint rnd16(input longint a);
    return (a + 64'sd32768) >>> 16;
  endfunction

  function automatic longint fade(input longint t);
    longint p;
    p = 6 * t - 15 * 65536;
    p = rnd16(t * p) + 10 * 65536;
    p = rnd16(t * p);
    p = rnd16(t * p);
    p = rnd16(t * p);
    if (p < 0) p = 0;
    if (p > 65536) p = 65536;
    return p;
  endfunction

  function automatic longint gdot(input logic [7:0] hv, input longint x, input longint y,
                                 input longint z);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint mix(input longint w, input longint a, input longint b);
    return a + rnd16(w * (b - a));
  endfunction

  function automatic logic [7:0] pt(input int i);
    return pn3_pkg::perm(8'(i));
  endfunction

  function automatic logic signed [15:0] noise_at(input logic [63:0] word);
    logic [19:0] c[3];
    int g[3];
    longint f[3], f1[3], s[3];
    int a, b, aa, ab, ba, bb;
    longint n000, n100, n010, n110, n001, n101, n011, n111, lo, hi, n, q;
    c[0] = word[19:0];
    c[1] = word[39:20];
    c[2] = word[59:40];
    for (int k = 0; k < 3; k++) begin
      g[k] = c[k][19:12];
      f[k] = longint'(c[k][11:0]) << 4;
      f1[k] = f[k] - 65536;
      s[k] = fade(f[k]);
    end
    a = pt(g[0]) + g[1];
    b = pt(g[0] + 1) + g[1];
    aa = pt(a) + g[2];
    ab = pt(a + 1) + g[2];
    ba = pt(b) + g[2];
    bb = pt(b + 1) + g[2];
    n000 = gdot(pt(aa), f[0], f[1], f[2]);
    n100 = gdot(pt(ba), f1[0], f[1], f[2]);
    n010 = gdot(pt(ab), f[0], f1[1], f[2]);
    n110 = gdot(pt(bb), f1[0], f1[1], f[2]);
    n001 = gdot(pt(aa + 1), f[0], f[1], f1[2]);
    n101 = gdot(pt(ba + 1), f1[0], f[1], f1[2]);
    n011 = gdot(pt(ab + 1), f[0], f1[1], f1[2]);
    n111 = gdot(pt(bb + 1), f1[0], f1[1], f1[2]);
    lo = mix(s[1], mix(s[0], n000, n100), mix(s[0], n010, n110));
    hi = mix(s[1], mix(s[0], n001, n101), mix(s[0], n011, n111));
    n = mix(s[2], lo, hi);
    q = shr_fl(n + 2, 2);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  initial begin
    err_count = 0;
    sat_hits = 0;
  end

  assign pending = noise_q.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) noise_q.push_back(noise_at(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (noise_q.size() == 0) report("unexpected word", m_axis_tdata, 16'h0);
        else begin
          if (m_axis_tdata !== noise_q[0]) report("noise_value", m_axis_tdata, noise_q[0]);
          if (noise_q[0] == 16'sh7FFF || noise_q[0] == -16'sh8000) sat_hits++;
          void'(noise_q.pop_front());
        end
      end
    end
  end

endmodule

>>> sim/tb_perlin_noise_3d.sv
`timescale 1ns / 100ps
module tb_perlin_noise_3d;

  localparam int N_RANDOM = 1730;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  int          err_count, pending, sat_hits;
  int          n_sent = 0;
  int          cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  perlin_noise_3d i_dut (.*);

  pn3_checker i_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off early on so the pipe backs up
  initial begin
    int gap;
    repeat (11) @(posedge clk);
    repeat (30) @(posedge clk);
    repeat (200) @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      @(posedge clk);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (m_axis_tvalid && gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [19:0] x, input logic [19:0] y, input logic [19:0] z,
                           input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, z, y, x};
    do @(posedge clk); while (!s_axis_tready);
    n_sent++;
  endtask

  function automatic logic [19:0] rand_coord(input int mode);
    case (mode)
      0: return 20'($urandom);
      1: return {8'($urandom), 12'($urandom_range(0, 3) * 'h555)};
      2: return {8'($urandom), ($urandom_range(0, 1) ? 12'h000 : 12'hFFF)};
      default: return {8'hFF, 12'($urandom)};
    endcase
  endfunction

  initial begin
    logic [19:0] ext[6];
    bit burst;
    ext = '{20'h00000, 20'hFFFFF, 20'h00FFF, 20'hFF000, 20'h00800, 20'hAAAAA};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // lattice corners, wrap at 255, fraction extremes and alternating bits
    for (int i = 0; i < 6; i++) send_word(ext[i], ext[i], ext[i], 0);
    send_word(20'h55555, 20'hAAAAA, 20'h55555, 0);
    send_word(20'hFFFFF, 20'h00000, 20'h00800, 0);
    send_word(20'h00800, 20'hFF800, 20'hFFFFF, 0);
    send_word(20'h01400, 20'h02C00, 20'h7F7FF, 0);
    // back-to-back while the receiver is held off
    for (int i = 0; i < 40; i++) send_word(rand_coord(0), rand_coord(0), rand_coord(0), 1);
    for (int i = 0; i < N_RANDOM; i++) begin
      burst = ($urandom_range(0, 9) < 3);
      send_word(rand_coord($urandom_range(0, 3)), rand_coord($urandom_range(0, 3)),
                rand_coord($urandom_range(0, 3)), burst);
    end
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("sent %0d coordinate words incl. wrap, fraction extremes and a long output stall",
             n_sent);
    $display("saturated results seen: %0d", sat_hits);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
